// ===== design/lom_pkg.sv =====
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types, codes and helpers for the limit order book matcher.
// ----------------------------------------------------------------------------
package lom_pkg;

	localparam int SLOTS  = 64;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = IDX_W + 1;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_CANCEL = 3'd1;
	localparam logic [2:0] OP_MODIFY = 3'd2;
	localparam logic [2:0] OP_MATCH  = 3'd3;
	localparam logic [2:0] OP_QUERY  = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_NOFILL   = 3'd5;

	typedef struct packed {
		logic        side;
		logic [31:0] key;
		logic [31:0] price;
		logic [31:0] total;
		logic [31:0] filled;
		logic [31:0] arrival;
	} slot_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] price;
		logic [31:0] qty;
	} fill_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] found_idx;
		slot_t            found_e;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		logic             bid_present;
		logic [31:0]      bid_price;
		logic [31:0]      bid_qty;
		logic             ask_present;
		logic [31:0]      ask_price;
		logic [31:0]      ask_qty;
		logic             opp_found;
		logic [IDX_W-1:0] opp_idx;
		slot_t            opp_e;
	} scan_t;

	function automatic logic [31:0] remaining(input logic [31:0] total,
		input logic [31:0] filled);
		return (total > filled) ? (total - filled) : 32'd0;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== design/limit_order_book_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority order book with add, cancel, modify, match and query.
// ----------------------------------------------------------------------------
// Results cannot be held off: each one appears on the result ports for a
// single cycle with strobe high, and busy stays high until the last result of
// an item has gone out. Every pass over the slot memory makes one read per
// slot, and the read data is registered. After the accepting edge, busy stays
// high while an add, cancel or modify runs a pass, an apply step, a second
// pass, a prepare step and its result, and while a query or a rejected code
// runs one pass, the prepare step and its result. A match takes one pass,
// then one check and one pass per fill, at most one more check when the walk
// stops on the limit or an empty side, then one prepare step and one result
// per cycle, as every fill carries the book top after the whole match.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [31:0] order_key,
	input  logic        side,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [31:0] aggressor_key,
	output logic [31:0] passive_key,
	output logic [31:0] fill_price,
	output logic [31:0] exec_qty,
	output logic        last,
	output logic        bid_present,
	output logic [31:0] best_bid_price,
	output logic [31:0] best_bid_qty,
	output logic        ask_present,
	output logic [31:0] best_ask_price,
	output logic [31:0] best_ask_qty
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN1  = 3'd1;
	localparam logic [2:0] S_APPLY  = 3'd2;
	localparam logic [2:0] S_SCAN2  = 3'd3;
	localparam logic [2:0] S_MCHK   = 3'd4;
	localparam logic [2:0] S_EPRIME = 3'd5;
	localparam logic [2:0] S_EOUT   = 3'd6;

	localparam logic [lom_pkg::CNT_W-1:0] SCAN_END = lom_pkg::CNT_W'(lom_pkg::SLOTS);

	logic [2:0]                  state_q;
	logic [2:0]                  op_q;
	logic [31:0]                 id_q;
	logic                        side_q;
	logic [31:0]                 price_q;
	logic [31:0]                 qty_q;
	logic [31:0]                 rem_q;
	logic [lom_pkg::CNT_W-1:0]   n_q;
	logic [lom_pkg::IDX_W-1:0]   eidx_q;
	logic [2:0]                  status_q;
	logic [31:0]                 counter_q;
	logic [lom_pkg::SLOTS-1:0]   valid_q;
	logic                        mloop_q;
	logic                        fillmode_q;
	logic [lom_pkg::CNT_W-1:0]   cnt_q;
	logic                        proc_s1;
	logic [lom_pkg::IDX_W-1:0]   idx_s1;

	logic                        scanning;
	logic                        scan_done;
	lom_pkg::slot_t              slot_rd;
	lom_pkg::slot_t              slot_wd;
	logic                        slot_we;
	logic [lom_pkg::IDX_W-1:0]   slot_wa;
	lom_pkg::fill_t              fill_rd;
	lom_pkg::fill_t              fill_wd;
	logic                        fill_we;
	logic [lom_pkg::IDX_W-1:0]   fill_ra;
	lom_pkg::scan_t              sr;

	// Apply and match step results.
	logic [2:0]                  ap_status;
	logic                        ap_set;
	logic                        ap_clr;
	logic                        ap_bump;
	logic                        new_px;
	logic [31:0]                 new_total;
	logic                        m_stop;
	logic [31:0]                 m_avail;
	logic [31:0]                 m_fill;
	logic                        m_gone;
	logic                        m_end;

	assign scanning  = (state_q == S_SCAN1) || (state_q == S_SCAN2);
	assign scan_done = scanning && (cnt_q == SCAN_END);

	lom_slot_mem u_slot_mem (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_wa),
		.wdata (slot_wd),
		.raddr (cnt_q[lom_pkg::IDX_W-1:0]),
		.rdata (slot_rd)
	);

	lom_fill_mem u_fill_mem (
		.clk   (clk),
		.we    (fill_we),
		.waddr (n_q[lom_pkg::IDX_W-1:0]),
		.wdata (fill_wd),
		.raddr (fill_ra),
		.rdata (fill_rd)
	);

	lom_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (scanning && cnt_q == '0),
		.en     (proc_s1),
		.idx    (idx_s1),
		.v      (valid_q[idx_s1]),
		.e      (slot_rd),
		.key    (id_q),
		.opp    (~side_q),
		.res    (sr)
	);

	always_comb begin
		ap_status = lom_pkg::ST_OK;
		ap_set    = 1'b0;
		ap_clr    = 1'b0;
		ap_bump   = 1'b0;
		slot_wd   = sr.found_e;
		slot_wa   = sr.found_idx;
		new_px    = (price_q != '0) && (price_q != sr.found_e.price);
		new_total = (qty_q != '0) ? qty_q : sr.found_e.total;
		unique case (op_q)
			lom_pkg::OP_ADD: begin
				slot_wd = '{side: side_q, key: id_q, price: price_q, total: qty_q,
					filled: 32'd0, arrival: counter_q};
				slot_wa = sr.free_idx;
				if (sr.found) begin
					ap_status = lom_pkg::ST_DUP;
				end else if (!sr.free_found) begin
					ap_status = lom_pkg::ST_FULL;
				end else begin
					ap_set  = 1'b1;
					ap_bump = 1'b1;
				end
			end
			lom_pkg::OP_CANCEL: begin
				if (!sr.found) begin
					ap_status = lom_pkg::ST_NOTFOUND;
				end else begin
					ap_clr = 1'b1;
				end
			end
			lom_pkg::OP_MODIFY: begin
				slot_wd.total = new_total;
				if (new_px) begin
					slot_wd.price   = price_q;
					slot_wd.arrival = counter_q;
				end
				if (!sr.found) begin
					ap_status = lom_pkg::ST_NOTFOUND;
				end else begin
					ap_bump = new_px;
					if (new_total <= sr.found_e.filled) begin
						ap_clr    = 1'b1;
						ap_status = lom_pkg::ST_INVALID;
					end
				end
			end
			default: begin
			end
		endcase

		m_stop = !sr.opp_found
			|| ((price_q != '0) && !side_q && (sr.opp_e.price > price_q))
			|| ((price_q != '0) && side_q && (sr.opp_e.price < price_q));
		m_avail = lom_pkg::remaining(sr.opp_e.total, sr.opp_e.filled);
		m_fill  = (rem_q < m_avail) ? rem_q : m_avail;
		m_gone  = (m_avail == m_fill);
		m_end   = (rem_q == m_fill) || (n_q == SCAN_END - 1'b1);
		fill_wd = '{key: sr.opp_e.key, price: sr.opp_e.price, qty: m_fill};

		slot_we = 1'b0;
		fill_we = 1'b0;
		if (state_q == S_APPLY) begin
			slot_we = ap_set || (op_q == lom_pkg::OP_MODIFY && sr.found);
		end else if (state_q == S_MCHK && !m_stop) begin
			slot_we        = 1'b1;
			fill_we        = 1'b1;
			slot_wa        = sr.opp_idx;
			slot_wd        = sr.opp_e;
			slot_wd.filled = sr.opp_e.filled + m_fill;
		end

		fill_ra = (state_q == S_EOUT) ? (eidx_q + 1'b1) : '0;
	end

	// Slot read pipeline: the scan sees the data of the address issued in the
	// previous cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_s1 <= 1'b0;
		end else begin
			proc_s1 <= scanning && (cnt_q != SCAN_END);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[lom_pkg::IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			valid_q    <= '0;
			counter_q  <= '0;
			mloop_q    <= 1'b0;
			fillmode_q <= 1'b0;
			n_q        <= '0;
			eidx_q     <= '0;
			status_q   <= lom_pkg::ST_OK;
			op_q       <= '0;
			id_q       <= '0;
			side_q     <= 1'b0;
			price_q    <= '0;
			qty_q      <= '0;
			rem_q      <= '0;
		end else begin
			if (scanning && !scan_done) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= operation;
						id_q     <= order_key;
						side_q   <= side;
						price_q  <= price;
						qty_q    <= quantity;
						rem_q    <= quantity;
						n_q      <= '0;
						cnt_q    <= '0;
						status_q <= lom_pkg::ST_OK;
						mloop_q  <= (operation == lom_pkg::OP_MATCH) && (quantity != '0);
						if (operation == lom_pkg::OP_CANCEL || operation == lom_pkg::OP_MODIFY
							|| (operation == lom_pkg::OP_ADD && quantity != '0)) begin
							state_q <= S_SCAN1;
						end else begin
							if (operation == lom_pkg::OP_ADD || operation > lom_pkg::OP_QUERY) begin
								status_q <= lom_pkg::ST_INVALID;
							end
							state_q <= S_SCAN2;
						end
					end
				end
				S_SCAN1: begin
					if (scan_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					status_q <= ap_status;
					if (ap_set) begin
						valid_q[sr.free_idx] <= 1'b1;
					end
					if (ap_clr) begin
						valid_q[sr.found_idx] <= 1'b0;
					end
					if (ap_bump) begin
						counter_q <= counter_q + 1'b1;
					end
					cnt_q   <= '0;
					state_q <= S_SCAN2;
				end
				S_SCAN2: begin
					if (scan_done) begin
						state_q <= mloop_q ? S_MCHK : S_EPRIME;
					end
				end
				S_MCHK: begin
					if (m_stop) begin
						mloop_q <= 1'b0;
						state_q <= S_EPRIME;
					end else begin
						if (m_gone) begin
							valid_q[sr.opp_idx] <= 1'b0;
						end
						rem_q   <= rem_q - m_fill;
						n_q     <= n_q + 1'b1;
						mloop_q <= !m_end;
						cnt_q   <= '0;
						state_q <= S_SCAN2;
					end
				end
				S_EPRIME: begin
					eidx_q     <= '0;
					fillmode_q <= (op_q == lom_pkg::OP_MATCH) && (n_q != '0);
					if (op_q == lom_pkg::OP_MATCH && n_q == '0) begin
						status_q <= lom_pkg::ST_NOFILL;
					end
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (!fillmode_q || last) begin
						state_q <= S_IDLE;
					end else begin
						eidx_q <= eidx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = (state_q == S_EOUT);

	always_comb begin
		if (fillmode_q) begin
			status        = lom_pkg::ST_OK;
			aggressor_key = id_q;
			passive_key   = fill_rd.key;
			fill_price    = fill_rd.price;
			exec_qty      = fill_rd.qty;
			last          = ({1'b0, eidx_q} + 1'b1) == n_q;
		end else begin
			status        = status_q;
			aggressor_key = (status_q == lom_pkg::ST_NOFILL) ? id_q : 32'd0;
			passive_key   = '0;
			fill_price    = '0;
			exec_qty      = '0;
			last          = 1'b1;
		end
	end

	assign bid_present    = sr.bid_present;
	assign best_bid_price = sr.bid_price;
	assign best_bid_qty   = sr.bid_qty;
	assign ask_present    = sr.ask_present;
	assign best_ask_price = sr.ask_price;
	assign best_ask_qty   = sr.ask_qty;

endmodule

// ===== design/lom_slot_mem.sv =====
// ----------------------------------------------------------------------------
// lom_slot_mem
// Order slot storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lom_slot_mem (
	input  logic                     clk,
	input  logic                     we,
	input  logic [lom_pkg::IDX_W-1:0] waddr,
	input  lom_pkg::slot_t           wdata,
	input  logic [lom_pkg::IDX_W-1:0] raddr,
	output lom_pkg::slot_t           rdata
);

	lom_pkg::slot_t mem [lom_pkg::SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/lom_fill_mem.sv =====
// ----------------------------------------------------------------------------
// lom_fill_mem
// Holds the fills of one match until the book top after the match is known.
// ----------------------------------------------------------------------------
module lom_fill_mem (
	input  logic                     clk,
	input  logic                     we,
	input  logic [lom_pkg::IDX_W-1:0] waddr,
	input  lom_pkg::fill_t           wdata,
	input  logic [lom_pkg::IDX_W-1:0] raddr,
	output lom_pkg::fill_t           rdata
);

	lom_pkg::fill_t mem [lom_pkg::SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/lom_scan.sv =====
// ----------------------------------------------------------------------------
// lom_scan
// Accumulates one pass over the slots: id lookup, first free slot, book top
// of both sides and the best resting order of the side opposite to a match.
// ----------------------------------------------------------------------------
module lom_scan (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     en,
	input  logic [lom_pkg::IDX_W-1:0] idx,
	input  logic                     v,
	input  lom_pkg::slot_t           e,
	input  logic [31:0]              key,
	input  logic                     opp,
	output lom_pkg::scan_t           res
);

	lom_pkg::scan_t res_q;
	logic [31:0]    rem;
	logic           opp_better;

	always_comb begin
		rem = lom_pkg::remaining(e.total, e.filled);
		if (!res_q.opp_found) begin
			opp_better = 1'b1;
		end else if (e.price != res_q.opp_e.price) begin
			opp_better = opp ? (e.price < res_q.opp_e.price) : (e.price > res_q.opp_e.price);
		end else begin
			opp_better = e.arrival < res_q.opp_e.arrival;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clr) begin
			res_q.found       <= 1'b0;
			res_q.free_found  <= 1'b0;
			res_q.bid_present <= 1'b0;
			res_q.bid_price   <= '0;
			res_q.bid_qty     <= '0;
			res_q.ask_present <= 1'b0;
			res_q.ask_price   <= '0;
			res_q.ask_qty     <= '0;
			res_q.opp_found   <= 1'b0;
		end else if (en) begin
			if (v && e.key == key && !res_q.found) begin
				res_q.found     <= 1'b1;
				res_q.found_idx <= idx;
				res_q.found_e   <= e;
			end
			if (!v && !res_q.free_found) begin
				res_q.free_found <= 1'b1;
				res_q.free_idx   <= idx;
			end
			if (v && !e.side) begin
				if (!res_q.bid_present || e.price > res_q.bid_price) begin
					res_q.bid_present <= 1'b1;
					res_q.bid_price   <= e.price;
					res_q.bid_qty     <= rem;
				end else if (e.price == res_q.bid_price) begin
					res_q.bid_qty <= lom_pkg::sat_add(res_q.bid_qty, rem);
				end
			end
			if (v && e.side) begin
				if (!res_q.ask_present || e.price < res_q.ask_price) begin
					res_q.ask_present <= 1'b1;
					res_q.ask_price   <= e.price;
					res_q.ask_qty     <= rem;
				end else if (e.price == res_q.ask_price) begin
					res_q.ask_qty <= lom_pkg::sat_add(res_q.ask_qty, rem);
				end
			end
			if (v && e.side == opp && opp_better) begin
				res_q.opp_found <= 1'b1;
				res_q.opp_idx   <= idx;
				res_q.opp_e     <= e;
			end
		end
	end

	assign res = res_q;

endmodule
